### rtl/core/mhpq_pkg.sv
// Shared types and constants for the max-heap priority queue.
package mhpq_pkg;

    localparam int DATA_W  = 32;
    localparam int COUNT_W = 11;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP,
        ST_LOAD,
        ST_DOWN,
        ST_FIN,
        ST_RESP
    } state_t;

    typedef struct packed {
        status_t                    status;
        logic signed [DATA_W-1:0]   removed_value;
        logic signed [DATA_W-1:0]   top_value;
        logic [COUNT_W-1:0]         count;
        logic                       is_empty;
    } result_t;

endpackage

### rtl/core/mhpq_if.sv
// Request and response channel interfaces of the max-heap priority queue.
interface mhpq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   cmd;
    logic signed [mhpq_pkg::DATA_W-1:0]     value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink (input valid, input cmd, input value, output ready);
endinterface

interface mhpq_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             status;
    logic signed [mhpq_pkg::DATA_W-1:0]     removed_value;
    logic signed [mhpq_pkg::DATA_W-1:0]     top_value;
    logic [mhpq_pkg::COUNT_W-1:0]           count;
    logic                                   is_empty;

    modport source (output valid, output status, output removed_value, output top_value,
                    output count, output is_empty, input ready);
    modport sink (input valid, input status, input removed_value, input top_value,
                  input count, input is_empty, output ready);
endinterface

### rtl/core/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [$clog2(DEPTH)-1:0]    waddr,
    input  logic [WIDTH-1:0]            wdata,
    input  logic [$clog2(DEPTH)-1:0]    raddr,
    output logic [WIDTH-1:0]            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/mhpq_store.sv
// Heap store: mirrored RAM pair for two reads per cycle plus a root copy.
module mhpq_store #(
    parameter int DEPTH = 1024
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [$clog2(DEPTH)-1:0]            waddr,
    input  logic signed [mhpq_pkg::DATA_W-1:0]  wdata,
    input  logic [$clog2(DEPTH)-1:0]            raddr_a,
    input  logic [$clog2(DEPTH)-1:0]            raddr_b,
    output logic signed [mhpq_pkg::DATA_W-1:0]  rdata_a,
    output logic signed [mhpq_pkg::DATA_W-1:0]  rdata_b,
    output logic signed [mhpq_pkg::DATA_W-1:0]  root
);

    localparam int AW = $clog2(DEPTH);

    logic [mhpq_pkg::DATA_W-1:0] ram_a_q;
    logic [mhpq_pkg::DATA_W-1:0] ram_b_q;
    logic signed [mhpq_pkg::DATA_W-1:0] root_reg;

    mhpq_ram #(
        .WIDTH (mhpq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_a),
        .rdata (ram_a_q)
    );

    mhpq_ram #(
        .WIDTH (mhpq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr_b),
        .rdata (ram_b_q)
    );

    always_ff @(posedge clk)
    begin
        if (we && (waddr == AW'(0)))
        begin
            root_reg <= wdata;
        end
    end

    assign rdata_a = $signed(ram_a_q);
    assign rdata_b = $signed(ram_b_q);
    assign root    = root_reg;

endmodule

### rtl/core/max_heap_priority_queue.sv
// Max-heap priority queue top level: sift sequencer, heap store and result register.
// Reject, insert into an empty heap or removal of the last value go straight to ST_RESP;
// an insert climbs in ST_UP; a removal fetches the last value in ST_LOAD and, unless
// it alone remains, sifts down in ST_DOWN. Sifts span up to log2(CAPACITY) levels.
// One item at a time. A waiting result does not block the next transfer in.
// Reset clears the count and control; the store needs no clearing pass.
module max_heap_priority_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    mhpq_req_if.sink        req,
    mhpq_rsp_if.source      rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = CW + 1;

    mhpq_pkg::state_t   state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic signed [mhpq_pkg::DATA_W-1:0] val_reg, val_next;
    logic signed [mhpq_pkg::DATA_W-1:0] removed_reg, removed_next;
    mhpq_pkg::status_t  status_reg, status_next;
    logic               rv_reg, rv_next;
    logic               out_valid_reg, out_valid_next;
    mhpq_pkg::result_t  out_data_reg, out_data_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic signed [mhpq_pkg::DATA_W-1:0] wdata;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    logic signed [mhpq_pkg::DATA_W-1:0] rdata_a;
    logic signed [mhpq_pkg::DATA_W-1:0] rdata_b;
    logic signed [mhpq_pkg::DATA_W-1:0] root;

    logic               accept;
    logic               slot_free;
    logic [CW-1:0]      count_m1;
    logic [AW-1:0]      parent;
    logic               pick_right;
    logic signed [mhpq_pkg::DATA_W-1:0] child_data;
    logic [IW-1:0]      child_ext;
    logic [AW-1:0]      child;
    logic [IW-1:0]      next_left;
    logic [IW-1:0]      next_right;

    mhpq_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b),
        .root    (root)
    );

    assign req.ready = (state_reg == mhpq_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign slot_free = !out_valid_reg || rsp.ready;

    assign count_m1   = count_reg - CW'(1);
    assign parent     = AW'((pos_reg - AW'(1)) >> 1);
    assign pick_right = rv_reg && (rdata_a < rdata_b);
    assign child_data = pick_right ? rdata_b : rdata_a;
    assign child_ext  = {CW'(pos_reg), 1'b0} + IW'(1) + IW'(pick_right);
    assign child      = child_ext[AW-1:0];
    assign next_left  = {child_ext[IW-2:0], 1'b1};
    assign next_right = next_left + IW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mhpq_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        val_reg      <= val_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        rv_reg       <= rv_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        rv_next        = rv_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = val_reg;
        raddr_a        = parent;
        raddr_b        = parent;

        case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    status_next  = mhpq_pkg::STAT_DONE;
                    val_next     = req.value;
                    pos_next     = count_reg[AW-1:0];
                    if (req.cmd == mhpq_pkg::CMD_INSERT)
                    begin
                        if (count_reg == CW'(CAPACITY))
                        begin
                            status_next = mhpq_pkg::STAT_FULL;
                            state_next  = mhpq_pkg::ST_RESP;
                        end
                        else
                        begin
                            count_next = count_reg + CW'(1);
                            if (count_reg == '0)
                            begin
                                we         = 1'b1;
                                waddr      = '0;
                                wdata      = req.value;
                                state_next = mhpq_pkg::ST_RESP;
                            end
                            else
                            begin
                                raddr_a    = AW'(count_m1 >> 1);
                                state_next = mhpq_pkg::ST_UP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = mhpq_pkg::STAT_EMPTY;
                            state_next  = mhpq_pkg::ST_RESP;
                        end
                        else
                        begin
                            removed_next = root;
                            count_next   = count_m1;
                            raddr_a      = count_m1[AW-1:0];
                            state_next   = (count_reg == CW'(1)) ? mhpq_pkg::ST_RESP
                                                                 : mhpq_pkg::ST_LOAD;
                        end
                    end
                end
            end

            mhpq_pkg::ST_UP:
            begin
                we = 1'b1;
                if (rdata_a < val_reg)
                begin
                    wdata    = rdata_a;
                    pos_next = parent;
                    raddr_a  = AW'((parent - AW'(1)) >> 1);
                    if (parent == '0)
                    begin
                        state_next = mhpq_pkg::ST_FIN;
                    end
                end
                else
                begin
                    state_next = mhpq_pkg::ST_RESP;
                end
            end

            mhpq_pkg::ST_LOAD:
            begin
                val_next = rdata_a;
                pos_next = '0;
                if (count_reg == CW'(1))
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = rdata_a;
                    state_next = mhpq_pkg::ST_RESP;
                end
                else
                begin
                    raddr_a    = AW'(1);
                    raddr_b    = AW'(2);
                    rv_next    = (IW'(2) < IW'(count_reg));
                    state_next = mhpq_pkg::ST_DOWN;
                end
            end

            mhpq_pkg::ST_DOWN:
            begin
                we = 1'b1;
                if (val_reg < child_data)
                begin
                    wdata    = child_data;
                    pos_next = child;
                    raddr_a  = next_left[AW-1:0];
                    raddr_b  = next_right[AW-1:0];
                    rv_next  = (next_right < IW'(count_reg));
                    if (!(next_left < IW'(count_reg)))
                    begin
                        state_next = mhpq_pkg::ST_FIN;
                    end
                end
                else
                begin
                    state_next = mhpq_pkg::ST_RESP;
                end
            end

            mhpq_pkg::ST_FIN:
            begin
                we         = 1'b1;
                state_next = mhpq_pkg::ST_RESP;
            end

            mhpq_pkg::ST_RESP:
            begin
                if (slot_free)
                begin
                    out_valid_next              = 1'b1;
                    out_data_next.status        = status_reg;
                    out_data_next.removed_value = removed_reg;
                    out_data_next.top_value     = (count_reg == '0) ? '0 : root;
                    out_data_next.count         = mhpq_pkg::COUNT_W'(count_reg);
                    out_data_next.is_empty      = (count_reg == '0);
                    state_next                  = mhpq_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mhpq_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_data_reg.status;
    assign rsp.removed_value = out_data_reg.removed_value;
    assign rsp.top_value     = out_data_reg.top_value;
    assign rsp.count         = out_data_reg.count;
    assign rsp.is_empty      = out_data_reg.is_empty;

`ifndef SYNTHESIS
    a_count_only_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("heap count changed without an input transfer");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("heap count above capacity");

    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == mhpq_pkg::ST_RESP)
        else $error("result loaded outside the response state");

    a_down_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mhpq_pkg::ST_DOWN |-> CW'(pos_reg) < count_reg)
        else $error("sift-down position beyond heap end");
`endif

endmodule
